@@ rtl/assert_macros.svh @@
// Assertion macros used by the peak picker datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TEPP_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("tepp assertion failed");
`define TEPP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("tepp implication failed");
`else
`define TEPP_ASSERT(lbl, clk, rstn, prop)
`define TEPP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/tepp_pkg.sv @@
// Package: constants, codes and controller/datapath interface structs.
`timescale 1ns / 1ps
`default_nettype none
package tepp_pkg;
	localparam int DEPTH    = 64;
	localparam int AW       = $clog2(DEPTH);
	localparam int FW       = AW + 1;
	localparam int SMP_BITS = 16;
	localparam int IDX_BITS = 32;
	localparam int VAL_BITS = 16;
	localparam int WIN_BITS = 6;
	localparam int DW       = 18;

	localparam logic [1:0] POL_ABS = 2'd0;
	localparam logic [1:0] POL_POS = 2'd1;
	localparam logic [1:0] POL_NEG = 2'd2;

	localparam logic [1:0] REG_MEAN = 2'd0;
	localparam logic [1:0] REG_THR  = 2'd1;
	localparam logic [1:0] REG_WIN  = 2'd2;
	localparam logic [1:0] REG_POL  = 2'd3;

	typedef struct packed {
		logic capture;
		logic rd_head;
		logic scan_first;
		logic scan_step;
		logic retire;
		logic write_new;
		logic clr_keep;
		logic step_count;
		logic end_reset;
		logic finalize;
	} cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic fill_full;
		logic cand;
		logic rec_end;
		logic best_valid;
		logic old;
		logic keep;
		logic push_ok;
		logic out_free;
		logic pend_valid;
		logic scan_done;
		logic need_clr;
	} stat_t;
endpackage
`default_nettype wire

@@ rtl/tepp_dp.sv @@
// Datapath: candidate ring memory, best tracking, scan and result staging.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tepp_dp (
	input  wire                              clk,
	input  wire                              arst_n,
	input  tepp_pkg::cmd_t                   cmd,
	output tepp_pkg::stat_t                  stat,
	input  wire signed [tepp_pkg::SMP_BITS-1:0] sample,
	input  wire                              rec_end,
	input  wire signed [15:0]                mean_offset,
	input  wire        [15:0]                abs_threshold,
	input  wire        [tepp_pkg::WIN_BITS-1:0] window_len,
	input  wire        [1:0]                 polarity,
	output logic                             out_valid,
	output logic [tepp_pkg::IDX_BITS-1:0]    out_index,
	output logic                             out_last,
	input  wire                              out_ready
);
	localparam int AW = tepp_pkg::AW;
	localparam int FW = tepp_pkg::FW;
	localparam int IB = tepp_pkg::IDX_BITS;
	localparam int VB = tepp_pkg::VAL_BITS;
	localparam int DW = tepp_pkg::DW;

	logic [IB+VB-1:0] mem_iv [tepp_pkg::DEPTH];
	logic             mem_k  [tepp_pkg::DEPTH];
	logic [IB+VB-1:0] rd_iv_q;
	logic             rd_k_q;

	logic [IB-1:0] cnt_q;
	logic [AW-1:0] head_q, best_slot_q, clr_slot_q;
	logic [FW-1:0] fill_q;
	logic          best_valid_q;
	logic [VB-1:0] best_val_q, v_q;
	logic          cand_q, end_q;
	logic [AW-1:0] scan_k_q, scan_slot_q, b_slot_q;
	logic [VB-1:0] b_val_q;
	logic          scan_first_q;
	logic          pend_valid_q;
	logic [IB-1:0] pend_idx_q;
	logic          out_valid_q, out_last_q;
	logic [IB-1:0] out_idx_q;

	// sample conditioning
	logic signed [DW-1:0] d, dp;
	logic                 cand_c;
	always_comb begin
		d = DW'(sample) - DW'(mean_offset);
		case (polarity)
			tepp_pkg::POL_POS: dp = d;
			tepp_pkg::POL_NEG: dp = -d;
			default:           dp = d[DW-1] ? -d : d;
		endcase
		cand_c = dp > $signed({2'b00, abs_threshold});
	end

	logic [IB-1:0] rd_idx;
	logic [VB-1:0] rd_val;
	logic [IB-1:0] age;
	logic          out_free, push_ok, gt_best, take;
	logic [AW-1:0] ns, new_b_slot;
	logic [VB-1:0] new_b_val;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	assign rd_idx  = rd_iv_q[IB+VB-1:VB];
	assign rd_val  = rd_iv_q[VB-1:0];
	assign age     = cnt_q - rd_idx;
	assign out_free = !out_valid_q || out_ready;
	assign push_ok = !pend_valid_q || out_free;
	assign gt_best = v_q > best_val_q;
	assign ns      = head_q + fill_q[AW-1:0];
	assign take    = scan_first_q || (rd_val > b_val_q);
	assign new_b_slot = take ? scan_slot_q : b_slot_q;
	assign new_b_val  = take ? rd_val : b_val_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		if (cmd.rd_head) begin
			rd_en = 1'b1;
		end else if (cmd.scan_first) begin
			rd_en   = 1'b1;
			rd_addr = head_q + AW'(fill_q - FW'(1));
		end else if (cmd.scan_step && scan_k_q != '0) begin
			rd_en   = 1'b1;
			rd_addr = head_q + (scan_k_q - AW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_new) begin
			mem_iv[ns] <= {cnt_q, v_q};
			mem_k[ns]  <= !best_valid_q || gt_best;
		end else if (cmd.clr_keep) begin
			mem_k[clr_slot_q] <= 1'b0;
		end
		if (rd_en) begin
			rd_iv_q <= mem_iv[rd_addr];
			rd_k_q  <= mem_k[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			v_q    <= dp[VB-1:0];
			cand_q <= cand_c;
			end_q  <= rec_end;
		end
		if (cmd.scan_first) begin
			scan_k_q     <= AW'(fill_q - FW'(1));
			scan_slot_q  <= rd_addr;
			scan_first_q <= 1'b1;
		end else if (cmd.scan_step) begin
			b_slot_q     <= new_b_slot;
			b_val_q      <= new_b_val;
			scan_first_q <= 1'b0;
			scan_k_q     <= scan_k_q - AW'(1);
			scan_slot_q  <= rd_addr;
		end
		if (cmd.write_new) begin
			clr_slot_q <= best_slot_q;
		end
		if (cmd.retire && rd_k_q) begin
			pend_idx_q <= rd_idx;
		end
		if ((cmd.retire && rd_k_q && pend_valid_q) || cmd.finalize) begin
			out_idx_q  <= pend_idx_q;
			out_last_q <= cmd.finalize;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			head_q       <= '0;
			fill_q       <= '0;
			best_slot_q  <= '0;
			best_valid_q <= 1'b0;
			best_val_q   <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.finalize || (cmd.retire && rd_k_q && pend_valid_q)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.retire) begin
				if (best_valid_q && best_slot_q == head_q) begin
					best_valid_q <= 1'b0;
				end
				head_q <= head_q + AW'(1);
				fill_q <= fill_q - FW'(1);
				if (rd_k_q) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (cmd.finalize) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.scan_step && scan_k_q == '0) begin
				best_slot_q  <= new_b_slot;
				best_val_q   <= new_b_val;
				best_valid_q <= 1'b1;
			end
			if (cmd.write_new) begin
				fill_q <= fill_q + FW'(1);
				if (!best_valid_q || gt_best) begin
					best_slot_q  <= ns;
					best_val_q   <= v_q;
					best_valid_q <= 1'b1;
				end
			end
			if (cmd.step_count) begin
				cnt_q <= cnt_q + IB'(1);
			end
			if (cmd.end_reset) begin
				cnt_q        <= '0;
				head_q       <= '0;
				best_slot_q  <= '0;
				best_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.fill_zero  = fill_q == '0;
		stat.fill_full  = fill_q[FW-1];
		stat.cand       = cand_q;
		stat.rec_end    = end_q;
		stat.best_valid = best_valid_q;
		stat.old        = age > IB'(window_len);
		stat.keep       = rd_k_q;
		stat.push_ok    = push_ok;
		stat.out_free   = out_free;
		stat.pend_valid = pend_valid_q;
		stat.scan_done  = scan_k_q == '0;
		stat.need_clr   = best_valid_q && gt_best;
	end

	assign out_valid = out_valid_q;
	assign out_index = out_idx_q;
	assign out_last  = out_last_q;

	`TEPP_ASSERT(a_fill_bound, clk, arst_n, fill_q <= FW'(tepp_pkg::DEPTH))
	`TEPP_ASSERT_IMP(a_best_held, clk, arst_n, best_valid_q, fill_q != '0)
	`TEPP_ASSERT_IMP(a_no_pend_idle, clk, arst_n, cmd.capture, !pend_valid_q)
endmodule
`default_nettype wire

@@ rtl/tepp_ctrl.sv @@
// Controller: sequences aging, candidate insert, window rescan and flush.
`timescale 1ns / 1ps
`default_nettype none
module tepp_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  tepp_pkg::stat_t stat,
	output tepp_pkg::cmd_t  cmd
);
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_AGE_RD  = 4'd1;
	localparam logic [3:0] S_AGE_CHK = 4'd2;
	localparam logic [3:0] S_CAND    = 4'd3;
	localparam logic [3:0] S_FULL    = 4'd4;
	localparam logic [3:0] S_SEL     = 4'd5;
	localparam logic [3:0] S_SCAN    = 4'd6;
	localparam logic [3:0] S_WRITE   = 4'd7;
	localparam logic [3:0] S_CLR     = 4'd8;
	localparam logic [3:0] S_END     = 4'd9;
	localparam logic [3:0] S_FLUSH   = 4'd10;
	localparam logic [3:0] S_FIN     = 4'd11;

	logic [3:0] state_q, state_d;
	logic       can_ret;
	assign can_ret  = !stat.keep || stat.push_ok;
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_AGE_RD;
				end
			end
			S_AGE_RD: begin
				if (stat.fill_zero) begin
					state_d = S_CAND;
				end else begin
					cmd.rd_head = 1'b1;
					state_d     = S_AGE_CHK;
				end
			end
			S_AGE_CHK: begin
				if (!stat.old) begin
					state_d = S_CAND;
				end else if (can_ret) begin
					cmd.retire = 1'b1;
					state_d    = S_AGE_RD;
				end
			end
			S_CAND: begin
				if (!stat.cand) begin
					state_d = S_END;
				end else if (stat.fill_full) begin
					cmd.rd_head = 1'b1;
					state_d     = S_FULL;
				end else begin
					state_d = S_SEL;
				end
			end
			S_FULL: begin
				if (can_ret) begin
					cmd.retire = 1'b1;
					state_d    = S_SEL;
				end
			end
			S_SEL: begin
				if (!stat.best_valid && !stat.fill_zero) begin
					cmd.scan_first = 1'b1;
					state_d        = S_SCAN;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.write_new = 1'b1;
				state_d       = stat.need_clr ? S_CLR : S_END;
			end
			S_CLR: begin
				cmd.clr_keep = 1'b1;
				state_d      = S_END;
			end
			S_END: begin
				if (!stat.rec_end) begin
					cmd.step_count = 1'b1;
					state_d        = S_FIN;
				end else if (stat.fill_zero) begin
					cmd.end_reset = 1'b1;
					state_d       = S_FIN;
				end else begin
					cmd.rd_head = 1'b1;
					state_d     = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (can_ret) begin
					cmd.retire = 1'b1;
					state_d    = S_END;
				end
			end
			S_FIN: begin
				if (!stat.pend_valid) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.finalize = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

@@ rtl/threshold_event_peak_picker.sv @@
// Top level: configuration registers, stream ports, controller and datapath.
// Sequencing: per transaction the controller ages out old ring entries, tests the sample,
//   retires the head on a full ring, rescans for the best if needed, inserts the candidate,
//   clears the beaten best's keep flag, and on record end flushes the ring.
// Throughput: one item at a time; the next waits for the ring walk and any output stalls.
// Reset: arst_n clears counter, ring, best and control; mean 0, thr 0, window 10, polarity abs.
`timescale 1ns / 1ps
`default_nettype none
module threshold_event_peak_picker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [15:0] s_tdata,   // [15:0] sample
	input  wire        s_tlast,   // record_end
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [31:0] m_tdata,  // [31:0] event_index
	output logic       m_tlast,   // run_last
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [1:0]  cfg_index,
	input  wire [15:0] cfg_data
);
	logic signed [15:0]                      mean_q;
	logic        [15:0]                      thr_q;
	logic        [tepp_pkg::WIN_BITS-1:0]    win_q;
	logic        [1:0]                       pol_q;
	logic                                    ctrl_ready;
	tepp_pkg::cmd_t  cmd;
	tepp_pkg::stat_t stat;

	// config writes only while the sequencer is idle; a pending write holds off
	// the next sample transaction
	assign cfg_ready = ctrl_ready;
	assign s_tready  = ctrl_ready && !cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			thr_q  <= '0;
			win_q  <= tepp_pkg::WIN_BITS'(10);
			pol_q  <= tepp_pkg::POL_ABS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tepp_pkg::REG_MEAN: mean_q <= cfg_data;
				tepp_pkg::REG_THR:  thr_q  <= cfg_data;
				tepp_pkg::REG_WIN:  win_q  <= cfg_data[tepp_pkg::WIN_BITS-1:0];
				tepp_pkg::REG_POL:  pol_q  <= cfg_data[1:0];
				default:            pol_q  <= pol_q;
			endcase
		end
	end

	// sequencer: one transaction in, walks the ring, then reopens s_tready
	tepp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid && !cfg_valid),
		.in_ready (ctrl_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// ring memory, best tracking, and a one-deep pending stage so the last
	// result of an item can be flagged before it reaches the output register
	tepp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.sample        (s_tdata),
		.rec_end       (s_tlast),
		.mean_offset   (mean_q),
		.abs_threshold (thr_q),
		.window_len    (win_q),
		.polarity      (pol_q),
		.out_valid     (m_tvalid),
		.out_index     (m_tdata),
		.out_last      (m_tlast),
		.out_ready     (m_tready)
	);
endmodule
`default_nettype wire

@@ tb/tb_threshold_event_peak_picker.sv @@
// Testbench for the threshold event peak picker: directed table, then random records.
`timescale 1ns / 1ps
`default_nettype none
module tb_threshold_event_peak_picker;
	localparam int RING_SLOTS  = 64;
	localparam int IDLE_LIMIT  = 20000; // cycles with no transaction anywhere
	localparam int DRAIN_WAIT  = 200;   // worst item latency, with margin
	localparam int RANDOM_ITEMS = 420;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = tepp_pkg::REG_MEAN;
	logic [15:0] cfg_data = '0;

	threshold_event_peak_picker u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One expected event: index and whether it closes the item's run.
	typedef struct packed {
		logic [31:0] index;
		logic        last;
	} event_t;

	event_t pending_events[$];
	int     fail_count = 0;
	int     events_seen = 0;
	int     items_sent = 0;
	bit     rx_stall_on = 1'b1;
	int     quiet_cycles = 0;

	// Predictor copy of registers and candidate ring.
	logic signed [15:0] pp_mean;
	logic [15:0]        pp_thr;
	logic [5:0]         pp_win;
	logic [1:0]         pp_pol;
	logic [31:0]        pp_count;
	logic [31:0]        pp_idx[RING_SLOTS];
	logic [16:0]        pp_val[RING_SLOTS];
	logic               pp_keep[RING_SLOTS];
	int                 pp_head, pp_fill, pp_best;
	bit                 pp_best_ok;
	event_t             item_events[$];

	function automatic void picker_reset();
		pp_mean = '0; pp_thr = '0; pp_win = 6'd10; pp_pol = tepp_pkg::POL_ABS;
		pp_count = '0; pp_head = 0; pp_fill = 0; pp_best = 0; pp_best_ok = 0;
	endfunction

	function automatic void retire_head();
		int s;
		s = pp_head;
		if (pp_best_ok && pp_best == s) pp_best_ok = 0;
		if (pp_keep[s] && item_events.size() < 64)
			item_events.push_back('{index: pp_idx[s], last: 1'b0});
		pp_head = (s + 1) % RING_SLOTS;
		pp_fill--;
	endfunction

	// Works out the events for one sample and queues them.
	function automatic void predict_events(logic [15:0] smp, logic rec_end);
		logic signed [33:0] d;
		logic [31:0] n, age;
		int k, b, s, ns;
		n = pp_count;
		item_events.delete();
		while (pp_fill > 0) begin
			age = n - pp_idx[pp_head];
			if (age <= {26'd0, pp_win}) break;
			retire_head();
		end
		d = 34'(signed'(smp)) - 34'(pp_mean);
		if (pp_pol == tepp_pkg::POL_NEG) d = -d;
		else if (pp_pol != tepp_pkg::POL_POS && d < 0) d = -d;
		if (d > $signed({18'd0, pp_thr})) begin
			if (pp_fill >= RING_SLOTS) retire_head();
			if (!pp_best_ok && pp_fill > 0) begin
				k = pp_fill - 1;
				b = (pp_head + k) % RING_SLOTS;
				while (k > 0) begin
					k--;
					s = (pp_head + k) % RING_SLOTS;
					if (pp_val[s] > pp_val[b]) b = s;
				end
				pp_best = b;
				pp_best_ok = 1;
			end
			ns = (pp_head + pp_fill) % RING_SLOTS;
			pp_idx[ns] = n;
			pp_val[ns] = d[16:0];
			if (pp_best_ok) begin
				if (d[16:0] > pp_val[pp_best]) begin
					pp_keep[ns] = 1; pp_keep[pp_best] = 0; pp_best = ns;
				end else begin
					pp_keep[ns] = 0;
				end
			end else begin
				pp_keep[ns] = 1; pp_best = ns; pp_best_ok = 1;
			end
			pp_fill++;
		end
		if (rec_end) begin
			while (pp_fill > 0) retire_head();
			pp_count = '0; pp_head = 0; pp_best_ok = 0; pp_best = 0;
		end else begin
			pp_count = n + 1;
		end
		if (item_events.size() > 0) item_events[item_events.size()-1].last = 1'b1;
		foreach (item_events[i]) pending_events.push_back(item_events[i]);
	endfunction

	// Output side: random stall bursts, checks at the rising edge.
	initial begin
		int burst;
		forever begin
			@(negedge clk);
			if (rx_stall_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 12);
				m_tready <= 1'b0;
				repeat (burst) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		event_t exp_ev;
		if (arst_n && m_tvalid && m_tready) begin
			events_seen++;
			if (pending_events.size() == 0) begin
				$error("unexpected event: index %0d last %0b", m_tdata, m_tlast);
				fail_count++;
			end else begin
				exp_ev = pending_events.pop_front();
				if (m_tdata !== exp_ev.index) begin
					$error("event_index: expected %0d, got %0d", exp_ev.index, m_tdata);
					fail_count++;
				end
				if (m_tlast !== exp_ev.last) begin
					$error("run_last: expected %0b, got %0b", exp_ev.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on any channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			tepp_pkg::REG_MEAN: pp_mean = val;
			tepp_pkg::REG_THR:  pp_thr = val;
			tepp_pkg::REG_WIN:  pp_win = val[5:0];
			default:            pp_pol = val[1:0];
		endcase
	endtask

	// Quiesce: all events out, then cover items that emit nothing.
	task automatic wait_drained();
		while (pending_events.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// One sample transaction; idle gaps optional. Stays on negedge afterwards.
	task automatic send_sample(logic [15:0] smp, logic rec_end, bit gaps);
		@(negedge clk);
		if (gaps && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
		s_tvalid <= 1'b1; s_tdata <= smp; s_tlast <= rec_end;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_events(smp, rec_end);
		items_sent++;
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic program_all(logic [15:0] m, logic [15:0] t, logic [5:0] w, logic [1:0] p);
		wait_drained();
		write_reg(tepp_pkg::REG_MEAN, m);
		write_reg(tepp_pkg::REG_THR, t);
		write_reg(tepp_pkg::REG_WIN, {10'd0, w});
		write_reg(tepp_pkg::REG_POL, {14'd0, p});
	endtask

	// Directed rows: sample, record end; expectations come from the predictor.
	typedef struct packed {
		logic [15:0] smp;
		logic        rec_end;
	} row_t;

	row_t directed_rows[] = '{
		'{16'h0000, 1'b0}, // at threshold 0: not a candidate
		'{16'h0001, 1'b0}, // smallest candidate
		'{16'h7FFF, 1'b0}, // largest positive
		'{16'h8000, 1'b0}, // most negative, magnitude wins
		'{16'h8000, 1'b0}, // tie keeps earlier best
		'{16'hFFFF, 1'b0},
		'{16'h0000, 1'b1}, // record end flushes held candidates
		'{16'h0005, 1'b1}  // single candidate at record end
	};

	initial begin
		logic [15:0] smp;
		picker_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values, absolute polarity.
		foreach (directed_rows[i]) send_sample(directed_rows[i].smp, directed_rows[i].rec_end, 0);

		// Positive polarity with extreme mean and window 0.
		program_all(16'h8000, 16'd0, 6'd0, tepp_pkg::POL_POS);
		send_sample(16'h7FFF, 0, 0);  // 65535 above mean
		send_sample(16'h8000, 0, 0);  // zero difference
		send_sample(16'h0000, 0, 0);
		send_sample(16'h0000, 1, 0);
		// Negative polarity, max threshold: nothing passes.
		program_all(16'h7FFF, 16'hFFFF, 6'd63, tepp_pkg::POL_NEG);
		send_sample(16'h8000, 0, 0);
		send_sample(16'h7FFF, 1, 0);
		// Polarity three behaves as absolute.
		program_all(16'h0000, 16'd100, 6'd3, 2'd3);
		send_sample(16'hFF00, 0, 0);
		send_sample(16'h0200, 0, 0);
		send_sample(16'h0000, 0, 0);
		send_sample(16'h0000, 0, 0);
		send_sample(16'h0000, 0, 0);
		send_sample(16'h0000, 0, 0);
		send_sample(16'h0150, 1, 0);

		// Random records, reconfigured between phases. Mostly spiky noise
		// with a modest threshold; the last phase runs without idling.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: program_all(16'd0, 16'd1000, 6'd10, tepp_pkg::POL_ABS);
				1: program_all(16'hFF00, 16'd500, 6'd63, tepp_pkg::POL_POS);
				2: program_all(16'd200, 16'd2000, 6'd1, tepp_pkg::POL_NEG);
				3: program_all(16'($urandom), 16'($urandom_range(0, 4000)),
					6'($urandom_range(0, 63)), 2'd3);
				4: program_all(16'($urandom_range(0, 400)), 16'd0, 6'd63,
					tepp_pkg::POL_ABS); // ring fills
				default: program_all(16'd0, 16'd3000, 6'($urandom_range(2, 20)),
					tepp_pkg::POL_ABS);
			endcase
			if (phase == 5) rx_stall_on = 1'b0;
			for (int it = 0; it < RANDOM_ITEMS / 6; it++) begin
				case ($urandom_range(0, 9))
					0:       smp = 16'($urandom);
					1:       smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
					2, 3:    smp = 16'($signed($urandom_range(0, 20000)) - 10000);
					default: smp = 16'($signed($urandom_range(0, 800)) - 400);
				endcase
				// Mid-phase window change once, while idle.
				if (phase == 2 && it == 30) begin
					wait_drained();
					write_reg(tepp_pkg::REG_WIN, 16'd5);
				end
				// Pause the sender until every event has come out.
				if (phase == 1 && it == 20) wait_drained();
				send_sample(smp, $urandom_range(0, 39) == 0, phase != 5);
			end
			send_sample(16'h0000, 1'b1, phase != 5);
		end

		while (pending_events.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Sent %0d samples over several register settings and polarities,", items_sent);
		$display("checked %0d emitted events including record-end flushes.", events_seen);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
